// ----- src/smt_pkg.sv -----
// ----------------------------------------------------------------------------
// smt_pkg
// Shared codes and controller/datapath interface types for the sorted table.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = 32;
  localparam int CNT_W    = 7;

  // request operation codes
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OP_W-1:0] OP_COUNT   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_MIN = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_MAX = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic load;    // capture request and set up the scan
    logic run;     // scan may issue table reads
    logic finish;  // commit table update and load the result
  } smt_cmd_t;

  typedef struct packed {
    logic scan_done;  // all reads issued
    logic busy;       // reads still outstanding
  } smt_sts_t;

endpackage

// ----- src/smt_ram.sv -----
// ----------------------------------------------------------------------------
// smt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module smt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- src/smt_ctrl.sv -----
// ----------------------------------------------------------------------------
// smt_ctrl
// Request sequencer: accepts a request, runs the table scan, hands off result.
// ----------------------------------------------------------------------------
module smt_ctrl
  import smt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output smt_cmd_t cmd_o,
  input  smt_sts_t sts_i
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.run    = 1'b0;
    cmd_o.finish = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_BUSY;
        end
      end
      S_BUSY: begin
        cmd_o.run = 1'b1;
        // hold the finished request until the result register frees up
        if (sts_i.scan_done && !sts_i.busy && out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/smt_datapath.sv -----
// ----------------------------------------------------------------------------
// smt_datapath
// Table storage, scan address generation, compare/shift logic and result regs.
// ----------------------------------------------------------------------------
module smt_datapath
  import smt_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smt_cmd_t                   cmd_i,
  output smt_sts_t                   sts_o,
  input  logic [OP_W-1:0]            op_i,
  input  logic signed [OUT_W-1:0]    value_i,
  output logic signed [OUT_W-1:0]    popped_value_o,
  output logic [CNT_W-1:0]           match_count_o,
  output logic                       found_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [CNT_W-1:0]           occupancy_o
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int EXT = (VALUE_WIDTH > OUT_W) ? VALUE_WIDTH : OUT_W;

  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          rem_q, rem_d;
  logic [AW-1:0]          addr_q, addr_d;
  logic [AW-1:0]          cur_q;
  logic                   pend_q;
  logic                   done_q, done_d;
  logic                   hit_q, hit_d;
  logic [CW-1:0]          match_q, match_d;
  logic [OP_W-1:0]        op_q;
  logic [VALUE_WIDTH-1:0] key_q;
  logic [VALUE_WIDTH-1:0] popped_q, popped_d;

  logic signed [EXT-1:0]  value_ext;
  logic                   full, empty, scan_down;
  logic                   rd_en;
  logic [VALUE_WIDTH-1:0] rdata;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [STATUS_W-1:0]    status_d;
  logic                   found_d;

  logic signed [OUT_W-1:0] popped_value_q;
  logic [CNT_W-1:0]        match_count_q;
  logic                    found_q;
  logic [STATUS_W-1:0]     status_q;
  logic [CNT_W-1:0]        occupancy_q;

  assign value_ext = EXT'(value_i);
  assign full      = (count_q == CW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign scan_down = (op_q == OP_INSERT) || (op_q == OP_POP_MAX);
  assign rd_en     = cmd_i.run && (rem_q != '0);

  assign sts_o.scan_done = (rem_q == '0);
  assign sts_o.busy      = pend_q;

  smt_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d  = count_q;
    rem_d    = rem_q;
    addr_d   = addr_q;
    done_d   = done_q;
    hit_d    = hit_q;
    match_d  = match_q;
    popped_d = popped_q;
    wr_en    = 1'b0;
    wr_addr  = cur_q;
    wr_data  = rdata;
    status_d = ST_OK;
    found_d  = 1'b0;

    if (cmd_i.load) begin
      done_d   = 1'b0;
      hit_d    = 1'b0;
      match_d  = '0;
      popped_d = '0;
      rem_d    = '0;
      addr_d   = '0;
      case (op_i)
        OP_INSERT: begin
          // walk down from the top, shifting entries greater or equal up by one
          if (!full) begin
            rem_d  = count_q;
            addr_d = AW'(count_q - CW'(1));
          end
        end
        OP_DELETE, OP_COUNT, OP_POP_MIN: begin
          if (!empty) begin
            rem_d = count_q;
          end
        end
        OP_POP_MAX: begin
          if (!empty) begin
            rem_d  = CW'(1);
            addr_d = AW'(count_q - CW'(1));
          end
        end
        default: begin
        end
      endcase
    end else begin
      if (rd_en) begin
        rem_d  = rem_q - CW'(1);
        addr_d = scan_down ? (addr_q - AW'(1)) : (addr_q + AW'(1));
      end

      if (pend_q) begin
        case (op_q)
          OP_INSERT: begin
            if (!done_q) begin
              wr_en   = 1'b1;
              wr_addr = cur_q + AW'(1);
              if ($signed(rdata) < $signed(key_q)) begin
                wr_data = key_q;
                done_d  = 1'b1;
              end
            end
          end
          OP_DELETE: begin
            // after the first match every later entry moves down by one
            if (hit_q) begin
              wr_en   = 1'b1;
              wr_addr = cur_q - AW'(1);
            end else if (rdata == key_q) begin
              hit_d = 1'b1;
            end
          end
          OP_COUNT: begin
            if (rdata == key_q) begin
              match_d = match_q + CW'(1);
              hit_d   = 1'b1;
            end
          end
          OP_POP_MIN: begin
            if (cur_q == '0) begin
              popped_d = rdata;
            end else begin
              wr_en   = 1'b1;
              wr_addr = cur_q - AW'(1);
            end
          end
          OP_POP_MAX: begin
            popped_d = rdata;
          end
          default: begin
          end
        endcase
      end

      if (cmd_i.finish) begin
        found_d = ((op_q == OP_DELETE) || (op_q == OP_COUNT)) && hit_q;
        case (op_q)
          OP_INSERT: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              count_d = count_q + CW'(1);
              // every entry was greater or equal: new value goes to the front
              if (!done_q) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = key_q;
              end
            end
          end
          OP_DELETE: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else if (hit_q) begin
              count_d = count_q - CW'(1);
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          OP_COUNT: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else if (!hit_q) begin
              status_d = ST_NOT_FOUND;
            end
          end
          OP_POP_MIN, OP_POP_MAX: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              count_d = count_q - CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rem_q   <= '0;
      addr_q  <= '0;
      cur_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
      match_q <= '0;
    end else begin
      count_q <= count_d;
      rem_q   <= rem_d;
      addr_q  <= addr_d;
      pend_q  <= rd_en;
      done_q  <= done_d;
      hit_q   <= hit_d;
      match_q <= match_d;
      if (rd_en) begin
        cur_q <= addr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    if (cmd_i.load) begin
      op_q  <= op_i;
      key_q <= value_ext[VALUE_WIDTH-1:0];
    end
    if (cmd_i.finish) begin
      popped_value_q <= OUT_W'($signed(popped_q));
      match_count_q  <= CNT_W'(match_q);
      found_q        <= found_d;
      status_q       <= status_d;
      occupancy_q    <= CNT_W'(count_d);
    end
  end

  assign popped_value_o = popped_value_q;
  assign match_count_o  = match_count_q;
  assign found_o        = found_q;
  assign status_o       = status_q;
  assign occupancy_o    = occupancy_q;

endmodule

// ----- src/sorted_multiset_table_core.sv -----
// scan: a request reads every entry held, one table read port stepped per entry
//   (insert, delete, count, pop min); pop max reads only the top entry; no entry
//   is read on insert into a full table, any request on an empty table, unused op
// one request at a time: the next request is taken only once the last has been
//   finished, which waits for its scan and for the result register to be free
// reset: entry count and handshake state cleared; table storage is not cleared
// ----------------------------------------------------------------------------
// sorted_multiset_table_core
// Bounded table of signed values kept in ascending order, duplicates allowed.
// ----------------------------------------------------------------------------
module sorted_multiset_table_core
  import smt_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic signed [OUT_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] popped_value_o,
  output logic [CNT_W-1:0]        match_count_o,
  output logic                    found_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic [CNT_W-1:0]        occupancy_o
);

  smt_cmd_t cmd;
  smt_sts_t sts;

  smt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  smt_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .value_i        (value_i),
    .popped_value_o (popped_value_o),
    .match_count_o  (match_count_o),
    .found_o        (found_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives sorted_multiset_table_core with a short directed table of requests,
// then with fill, drain and mixed phases of random requests, with random
// gaps and stalls on both handshakes. Every result is checked field by field
// against a queue-based model of the sorted table or a row's typed result.
// ----------------------------------------------------------------------------
module testbench;
  import smt_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int N_RANDOM    = 925;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_WAIT = 80;
  localparam int POOL_N      = 8;

  // op codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] popped_value;
    logic [CNT_W-1:0]        match_count;
    logic                    found;
    logic [STATUS_W-1:0]     status;
    logic [CNT_W-1:0]        occupancy;
  } table_result_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [OUT_W-1:0] value;
    logic                    has_result;
    table_result_t           result;
  } request_row_t;

  localparam int N_DIRECTED = 25;

  // rows with has_result set carry the result read straight off the behavior
  request_row_t directed_rows [N_DIRECTED] = '{
    '{OP_COUNT,     32'sd0,           1'b1, '{32'sd0, 7'd0, 1'b0, ST_EMPTY,     7'd0}},
    '{OP_DELETE,    32'sd5,           1'b1, '{32'sd0, 7'd0, 1'b0, ST_EMPTY,     7'd0}},
    '{OP_POP_MIN,   32'sd7,           1'b1, '{32'sd0, 7'd0, 1'b0, ST_EMPTY,     7'd0}},
    '{OP_POP_MAX,   -32'sd7,          1'b1, '{32'sd0, 7'd0, 1'b0, ST_EMPTY,     7'd0}},
    '{OP_SPARE_LO,  32'sd0,           1'b1, '{32'sd0, 7'd0, 1'b0, ST_OK,        7'd0}},
    '{OP_INSERT,    32'sh7fffffff,    1'b1, '{32'sd0, 7'd0, 1'b0, ST_OK,        7'd1}},
    '{OP_INSERT,    32'sh80000000,    1'b1, '{32'sd0, 7'd0, 1'b0, ST_OK,        7'd2}},
    '{OP_INSERT,    32'sd0,           1'b0, '0},
    '{OP_INSERT,    32'sd0,           1'b0, '0},
    '{OP_INSERT,    -32'sd1,          1'b0, '0},
    '{OP_COUNT,     32'sd0,           1'b0, '0},
    '{OP_COUNT,     32'sh7fffffff,    1'b0, '0},
    '{OP_COUNT,     32'sd5,           1'b1, '{32'sd0, 7'd0, 1'b0, ST_NOT_FOUND, 7'd5}},
    '{OP_DELETE,    32'sd5,           1'b1, '{32'sd0, 7'd0, 1'b0, ST_NOT_FOUND, 7'd5}},
    '{OP_DELETE,    32'sd0,           1'b0, '0},
    '{OP_SPARE_MID, 32'shffffffff,    1'b1, '{32'sd0, 7'd0, 1'b0, ST_OK,        7'd4}},
    '{OP_SPARE_HI,  32'sh55555555,    1'b1, '{32'sd0, 7'd0, 1'b0, ST_OK,        7'd4}},
    '{OP_POP_MIN,   32'shffffffff,    1'b0, '0},
    '{OP_POP_MAX,   32'sh00000000,    1'b0, '0},
    '{OP_DELETE,    -32'sd1,          1'b0, '0},
    '{OP_POP_MAX,   32'shaaaaaaaa,    1'b0, '0},
    '{OP_POP_MIN,   32'sd1,           1'b1, '{32'sd0, 7'd0, 1'b0, ST_EMPTY,     7'd0}},
    '{OP_INSERT,    32'sh80000000,    1'b0, '0},
    '{OP_COUNT,     32'sh80000000,    1'b0, '0},
    '{OP_POP_MAX,   32'sd3,           1'b0, '0}
  };

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    req_valid = 1'b0;
  logic                    req_ready;
  logic [OP_W-1:0]         req_op    = OP_INSERT;
  logic signed [OUT_W-1:0] req_value = '0;
  logic                    res_valid;
  logic                    res_ready = 1'b0;
  logic signed [OUT_W-1:0] res_popped_value;
  logic [CNT_W-1:0]        res_match_count;
  logic                    res_found;
  logic [STATUS_W-1:0]     res_status;
  logic [CNT_W-1:0]        res_occupancy;

  logic signed [OUT_W-1:0] held_values [$];
  logic signed [OUT_W-1:0] value_pool [POOL_N];
  table_result_t           pending_results [$];
  bit                      no_idle = 1'b0;
  int                      error_count = 0;
  int                      cycle_count = 0;

  sorted_multiset_table_core #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (OUT_W)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (req_valid),
    .in_ready_o     (req_ready),
    .op_i           (req_op),
    .value_i        (req_value),
    .out_valid_o    (res_valid),
    .out_ready_i    (res_ready),
    .popped_value_o (res_popped_value),
    .match_count_o  (res_match_count),
    .found_o        (res_found),
    .status_o       (res_status),
    .occupancy_o    (res_occupancy)
  );

  always #2 clk = ~clk;

  // applies one request to the sorted table copy and returns its result
  function automatic table_result_t apply_request(input logic [OP_W-1:0] op,
                                                  input logic signed [OUT_W-1:0] value);
    table_result_t r;
    int            pos;
    int            hits;
    r    = '0;
    pos  = 0;
    hits = 0;
    if (op == OP_INSERT) begin
      if (held_values.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        while (pos < held_values.size() && held_values[pos] < value) pos++;
        held_values.insert(pos, value);
      end
    end else if (op <= OP_POP_MAX) begin
      if (held_values.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        case (op)
          OP_DELETE: begin
            while (pos < held_values.size() && held_values[pos] != value) pos++;
            if (pos < held_values.size()) begin
              r.found = 1'b1;
              held_values.delete(pos);
            end else begin
              r.status = ST_NOT_FOUND;
            end
          end
          OP_COUNT: begin
            foreach (held_values[i]) if (held_values[i] == value) hits++;
            r.match_count = hits[CNT_W-1:0];
            if (hits != 0) r.found = 1'b1;
            else r.status = ST_NOT_FOUND;
          end
          OP_POP_MIN: r.popped_value = held_values.pop_front();
          default:    r.popped_value = held_values.pop_back();
        endcase
      end
    end
    r.occupancy = CNT_W'(held_values.size());
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return value_pool[$urandom_range(0, POOL_N - 1)];
    if (roll < 70) begin
      case ($urandom_range(0, 4))
        0:       return 32'sh80000000;
        1:       return 32'sh7fffffff;
        2:       return 32'sd0;
        3:       return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic issue_request(input logic [OP_W-1:0] op,
                               input logic signed [OUT_W-1:0] value,
                               input logic has_result,
                               input table_result_t typed_result);
    int            gap;
    table_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_op    <= op;
    req_value <= value;
    do @(posedge clk); while (!req_ready);
    predicted = apply_request(op, value);
    pending_results.push_back(has_result ? typed_result : predicted);
  endtask

  // hold off new requests until every result is back
  task automatic wait_results_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin : request_source
    phase_e                  phase;
    int                      phase_len;
    int                      insert_share;
    int                      roll;
    int                      random_sent;
    logic [OP_W-1:0]         op;
    logic signed [OUT_W-1:0] value;
    random_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].op, directed_rows[i].value,
                    directed_rows[i].has_result, directed_rows[i].result);
    wait_results_idle();

    while (random_sent < N_RANDOM) begin
      phase     = phase_e'($urandom_range(0, 2));
      phase_len = $urandom_range(40, 110);
      no_idle   = ($urandom_range(0, 3) == 0);
      foreach (value_pool[i])
        value_pool[i] = $urandom_range(0, 1) ? $urandom_range(0, 20) - 10 : $urandom();
      insert_share = (phase == PHASE_FILL) ? 85 : (phase == PHASE_DRAIN) ? 15 : 45;
      if ($urandom_range(0, 2) == 0) wait_results_idle();
      for (int k = 0; k < phase_len && random_sent < N_RANDOM; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else if (roll < insert_share) op = OP_INSERT;
        else op = OP_W'($urandom_range(OP_DELETE, OP_POP_MAX));
        // delete and count mostly aim at entries that are held
        if ((op == OP_DELETE || op == OP_COUNT) && held_values.size() != 0 &&
            $urandom_range(0, 99) < 65)
          value = held_values[$urandom_range(0, held_values.size() - 1)];
        else if (op == OP_POP_MIN || op == OP_POP_MAX || op >= OP_SPARE_LO)
          value = $urandom();
        else
          value = pick_value();
        issue_request(op, value, 1'b0, '0);
        random_sent++;
      end
    end

    wait_results_idle();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("sorted_multiset_table_core: match");
    end else begin
      $display("sorted_multiset_table_core: mismatch");
    end
    $finish;
  end

  initial begin : result_sink
    int            stall;
    table_result_t want;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall == 0) begin
        res_ready <= 1'b1;
      end else begin
        // stall counted from the moment a result is offered
        res_ready <= 1'b0;
        do @(posedge clk); while (!res_valid);
        repeat (stall - 1) @(posedge clk);
        res_ready <= 1'b1;
      end
      do @(posedge clk); while (!(res_valid && res_ready));
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_popped_value !== want.popped_value) begin
          $error("popped_value: expected %0d, got %0d", want.popped_value, res_popped_value);
          error_count++;
        end
        if (res_match_count !== want.match_count) begin
          $error("match_count: expected %0d, got %0d", want.match_count, res_match_count);
          error_count++;
        end
        if (res_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, res_found);
          error_count++;
        end
        if (res_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_status);
          error_count++;
        end
        if (res_occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, res_occupancy);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_multiset_table_core: mismatch");
    $finish;
  end

endmodule
